[rtl/core/fprf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprf_pkg
// Shared widths and types of the fixed point to reduced fraction unit.
// ----------------------------------------------------------------------------
package fprf_pkg;
    localparam int WORD_W = 32;
    localparam int WIDE_W = 64;
    localparam logic [WORD_W-1:0] PRECISION_RESET = 32'd1048576;

    typedef logic [WORD_W-1:0]        t_word;
    typedef logic signed [WORD_W-1:0] t_sword;
    typedef logic signed [WIDE_W-1:0] t_swide;

    typedef struct packed {
        logic start;
        logic done;
    } t_iter_ctl;
endpackage
`default_nettype wire

[rtl/core/fprf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprf channel interfaces
// Valid/ready channels for input, result and configuration beats.
// ----------------------------------------------------------------------------
interface fprf_in_if;
    logic                 valid;
    logic                 ready;
    fprf_pkg::t_sword     integer_part;
    fprf_pkg::t_word      fraction;
    modport source (output valid, output integer_part, output fraction, input ready);
    modport sink   (input valid, input integer_part, input fraction, output ready);
endinterface

interface fprf_out_if;
    logic                 valid;
    logic                 ready;
    fprf_pkg::t_swide     numerator;
    fprf_pkg::t_word      denominator;
    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface fprf_cfg_if;
    logic                 valid;
    logic                 ready;
    fprf_pkg::t_word      data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/fixed_point_to_reduced_fraction_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_to_reduced_fraction_unit
// Turns a signed fixed-point number into a reduced fraction.
// ----------------------------------------------------------------------------
// One item at a time: the fraction is scaled by the precision register and
// rounded half up, the pair scaled/precision is reduced by a binary gcd, and
// the result integer*deno + num over deno is returned. An item goes through
// scaling, the start of the gcd unit, the gcd steps (one per cycle, their
// number set by the operand bits), the two quotients of the shared
// subtractor, the hand-back of the quotients, the final multiply-add, the
// output beat and the idle state that takes the next input. Input ready is
// high only while idle. A precision of 0 is used as 1.
module fixed_point_to_reduced_fraction_unit #(
    parameter int FRACTION_BITS = 32,
    parameter int INTEGER_BITS  = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    fprf_cfg_if.sink     i_cfg,
    fprf_in_if.sink      i_in,
    fprf_out_if.source   o_out
);
    import fprf_pkg::*;

    localparam int ISH = WORD_W - INTEGER_BITS;
    localparam int FSH = WORD_W - FRACTION_BITS;
    localparam logic [WIDE_W:0] ROUND_HALF = (WIDE_W+1)'(1) << (FRACTION_BITS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ITER  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  r_state;
    t_word       r_precision, r_p, r_frac, r_scaled;
    t_sword      r_ival;
    t_swide      r_prod, r_numer;
    t_word       r_deno;
    t_iter_ctl   iter_in, iter_out;
    t_word       it_num, it_deno;
    logic [WIDE_W:0] rsum;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_precision <= PRECISION_RESET;
        end else if (i_cfg.valid) begin
            r_precision <= i_cfg.data;
        end
    end

    assign rsum = {1'b0, r_prod} + ROUND_HALF;
    // start is held through S_ITER; the gcd unit takes it in the first cycle of S_ITER, once r_scaled is set
    assign iter_in.start = (r_state == S_ITER);
    assign iter_in.done  = 1'b0;

    fprf_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (iter_in),
        .o_ctl    (iter_out),
        .i_scaled (r_scaled),
        .i_p      (r_p),
        .o_num    (it_num),
        .o_deno   (it_deno)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_ival  <= $signed(i_in.integer_part << ISH) >>> ISH;
                        r_frac  <= i_in.fraction & ({WORD_W{1'b1}} >> FSH);
                        r_p     <= (r_precision == '0) ? t_word'(1) : r_precision;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_prod  <= WIDE_W'(r_frac) * WIDE_W'(r_p);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    // scaled never exceeds precision, so it fits a word
                    r_scaled <= rsum[FRACTION_BITS +: WORD_W];
                    r_state  <= S_ITER;
                end
                S_ITER: begin
                    if (iter_out.done) begin
                        r_deno  <= it_deno;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= t_swide'(r_ival) * $signed({1'b0, r_deno});
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_numer <= r_prod + t_swide'({32'b0, it_num});
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.numerator   = r_numer;
    assign o_out.denominator = r_deno;
endmodule
`default_nettype wire

[rtl/core/fprf_iter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprf_iter
// Binary gcd of scaled and precision, then two restoring divisions by the
// gcd, all on one shared 33-bit subtractor.
// ----------------------------------------------------------------------------
module fprf_iter (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  fprf_pkg::t_iter_ctl  i_ctl,
    output fprf_pkg::t_iter_ctl  o_ctl,
    input  fprf_pkg::t_word      i_scaled,
    input  fprf_pkg::t_word      i_p,
    output fprf_pkg::t_word      o_num,
    output fprf_pkg::t_word      o_deno
);
    import fprf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIVA = 3'd2;
    localparam logic [2:0] S_DIVB = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_state;
    t_word       r_a, r_b, r_g, r_quo, r_num, r_sc, r_p;
    logic [4:0]  r_k, r_cnt;
    logic [32:0] r_rem;

    logic        a_ge_b;
    logic [32:0] op_x, op_y, rem_sh;
    logic [33:0] diff;

    assign a_ge_b = (r_a >= r_b);
    assign rem_sh = {r_rem[31:0], r_quo[31]};

    // shared subtractor: larger minus smaller in gcd, trial subtract in divide
    always_comb begin
        if (r_state == S_GCD) begin
            op_x = a_ge_b ? {1'b0, r_a} : {1'b0, r_b};
            op_y = a_ge_b ? {1'b0, r_b} : {1'b0, r_a};
        end else begin
            op_x = rem_sh;
            op_y = {1'b0, r_g};
        end
        diff = {1'b0, op_x} - {1'b0, op_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_a     <= i_scaled;
                        r_b     <= i_p;
                        r_sc    <= i_scaled;
                        r_p     <= i_p;
                        r_k     <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_a == '0) begin
                        r_g     <= r_b << r_k;
                        r_quo   <= r_sc;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVA;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 5'd1;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (a_ge_b) begin
                        r_a <= diff[31:0];
                    end else begin
                        r_b <= diff[31:0];
                    end
                end
                S_DIVA, S_DIVB: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31 && r_state == S_DIVA) begin
                        // last numerator bit, then load precision as dividend
                        r_num   <= {r_quo[30:0], ~diff[33]};
                        r_quo   <= r_p;
                        r_rem   <= '0;
                        r_state <= S_DIVB;
                    end else begin
                        if (diff[33]) begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[30:0], 1'b0};
                        end else begin
                            r_rem <= diff[32:0];
                            r_quo <= {r_quo[30:0], 1'b1};
                        end
                        if (r_cnt == 5'd31) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.done  = (r_state == S_DONE);
    assign o_num       = r_num;
    assign o_deno      = r_quo;
endmodule
`default_nettype wire

[rtl/core/fprf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprf_checker
// Port-level checks of the fixed point to reduced fraction unit.
// ----------------------------------------------------------------------------
module fprf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_out_denominator
);
    // a result beat waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before taken");

    // one item in flight: never ready for input while a result is shown
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while result pending");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid && !i_in_ready)
        else $error("result or ready right after input beat");

    a_deno_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_denominator != 32'd0)
        else $error("zero denominator");
endmodule

bind fixed_point_to_reduced_fraction_unit fprf_checker u_fprf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_denominator (o_out.denominator)
);
`default_nettype wire
